// ===== rtl/periodic_piecewise_linear_waveform_core_assert.svh =====
// assertion macros for the waveform core
// used by periodic_piecewise_linear_waveform_core, expects i_clk and i_rst_n in scope
`ifndef PERIODIC_PIECEWISE_LINEAR_WAVEFORM_CORE_ASSERT_SVH
`define PERIODIC_PIECEWISE_LINEAR_WAVEFORM_CORE_ASSERT_SVH

// condition holds in the same cycle
`define PPWL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after
`define PPWL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ppwl_pkg.sv =====
// shared types and constants of the piecewise-linear waveform core
// no dependencies
package ppwl_pkg;

    localparam int VAL_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W    = 67;
    localparam int MAG_A_W   = 34;
    localparam int MAG_B_W   = 33;
    localparam int QUO_W     = 35;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_TIME = 1'b1;

    localparam logic [1:0] ST_INTERP    = 2'd0;
    localparam logic [1:0] ST_BEFORE    = 2'd1;
    localparam logic [1:0] ST_CUTOFF    = 2'd2;
    localparam logic [1:0] ST_ZERO_SPAN = 2'd3;

    localparam logic signed [31:0] AMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] AMP_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               operation;
        logic [3:0]         point_index;
        logic signed [31:0] time_value;
        logic signed [31:0] amp_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] amplitude;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LAST,
        S_CHECK,
        S_MOD,
        S_SEEK_START,
        S_SEEK,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== rtl/ppwl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ppwl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/periodic_piecewise_linear_waveform_core.sv =====
// periodic piecewise-linear waveform core: breakpoint table and evaluator
// depends on ppwl_pkg, ppwl_ram and periodic_piecewise_linear_waveform_core_assert.svh
//
//   channel   direction  handshake              payload
//   in        to core    i_in_valid/o_in_stall  t_in_item  (load or evaluate)
//   out       from core  o_out_valid/i_out_stall t_out_item (one per evaluate)
//   cfg       to core    i_cfg_we               i_cfg_idx, i_cfg_data
//
// a load is written as it is accepted and leaves the core idle; an evaluate that ends early
// (before start, after cutoff, zero span) stops after the check, a zero-length segment after
// the modulo and the table walk over the n breakpoints in use (at most MAX_POINTS), and a full
// interpolation after the 32-step modulo, the one-entry-a-cycle table walk, the 34-step multiply and 67-step divide
// reset is synchronous and active low; the table has no reset and reads back
// only what was loaded. a result held by a stalled output does not block the
// next item until its own result is ready to be written
`include "periodic_piecewise_linear_waveform_core_assert.svh"

module periodic_piecewise_linear_waveform_core #(
    parameter int unsigned MAX_POINTS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  ppwl_pkg::t_in_item                     i_in_item,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output ppwl_pkg::t_out_item                    o_out_item,
    input  logic                                   i_cfg_we,
    input  logic [ppwl_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ppwl_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    import ppwl_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    // control
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // configuration
    logic [4:0]         r_point_count;
    logic signed [31:0] r_cutoff;

    // evaluation working set
    logic signed [31:0]  r_tq, n_tq;
    logic signed [31:0]  r_t1, n_t1;      // segment start, also first breakpoint
    logic signed [31:0]  r_f1, n_f1;
    logic [AW-1:0]       r_last, n_last;
    logic [AW-1:0]       r_k, n_k;
    logic signed [33:0]  r_ts, n_ts;      // wrapped query time
    logic [PROD_W-1:0]   r_dvd, n_dvd;    // dividend shifter, also product accumulator
    logic [MAG_B_W-1:0]  r_dvs, n_dvs;
    logic [33:0]         r_rem, n_rem;
    logic [QUO_W-1:0]    r_quo, n_quo;
    logic                r_qovf, n_qovf;
    logic [MAG_A_W-1:0]  r_mpl, n_mpl;
    logic [MAG_B_W-1:0]  r_mcd, n_mcd;
    logic [6:0]          r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic signed [31:0]  r_res_amp, n_res_amp;
    logic [1:0]          r_res_status, n_res_status;
    logic                r_from_div, n_from_div;

    // table memory: {time, amplitude}
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic [63:0]         w_rdata;
    logic signed [31:0]  w_rd_time;
    logic signed [31:0]  w_rd_amp;

    logic                w_in_acc;
    logic [31:0]         w_n;
    logic                w_idx_ok;

    // shared restoring divider step
    logic [33:0]         w_rr;
    logic                w_ge;
    logic [33:0]         w_rnext;

    // check stage
    logic signed [32:0]  w_span;
    logic [32:0]         w_span_mag;
    logic [31:0]         w_offset;

    // seek stage
    logic                w_hit;
    logic                w_at_last;
    logic signed [34:0]  w_a;
    logic signed [32:0]  w_b;
    logic signed [32:0]  w_c;
    logic signed [34:0]  w_a_neg;
    logic signed [32:0]  w_b_neg;
    logic signed [32:0]  w_c_neg;
    logic signed [32:0]  w_fsum;

    // final rounding and saturation
    logic                w_round;
    logic [35:0]         w_qq;
    logic signed [37:0]  w_sv;
    logic signed [37:0]  w_sum;
    logic signed [31:0]  w_sat;

    ppwl_ram #(
        .WIDTH(64),
        .DEPTH(MAX_POINTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata({i_in_item.time_value, i_in_item.amp_value}),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd_time = $signed(w_rdata[63:32]);
    assign w_rd_amp  = $signed(w_rdata[31:0]);

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // clamp of the breakpoint count to [2, MAX_POINTS]
    assign w_n = (r_point_count < 5'd2) ? 32'd2 :
                 ((32'(r_point_count) > MAX_POINTS) ? 32'(MAX_POINTS) : 32'(r_point_count));

    assign w_idx_ok = 32'(i_in_item.point_index) < MAX_POINTS;
    assign w_we     = w_in_acc && (i_in_item.operation == OP_LOAD) && w_idx_ok;
    assign w_waddr  = AW'(i_in_item.point_index);

    // read address follows the state: first entry, last entry, then the walk
    always_comb begin
        unique case (r_state)
            S_RD_LAST:    w_raddr = r_last;
            S_SEEK_START: w_raddr = AW'(1);
            S_SEEK:       w_raddr = AW'(r_k + AW'(2));
            default:      w_raddr = '0;
        endcase
    end

    // one restoring step, msb of the dividend shifter first
    assign w_rr    = {r_rem[32:0], r_dvd[PROD_W-1]};
    assign w_ge    = w_rr >= {1'b0, r_dvs};
    assign w_rnext = w_ge ? (w_rr - {1'b0, r_dvs}) : w_rr;

    // span and wrap offset against the first breakpoint
    assign w_span     = 33'(w_rd_time) - 33'(r_t1);
    assign w_span_mag = w_span[32] ? 33'(-w_span) : 33'(w_span);
    assign w_offset   = 32'(33'(r_tq) - 33'(r_t1));

    // segment [t1, t2] with t2 just read
    assign w_hit     = (r_ts <= 34'(w_rd_time)) && (r_ts >= 34'(r_t1));
    assign w_at_last = (AW'(r_k + AW'(1)) == r_last);
    assign w_a       = 35'(r_ts) - 35'(r_t1);
    assign w_b       = 33'(w_rd_amp) - 33'(r_f1);
    assign w_c       = 33'(w_rd_time) - 33'(r_t1);
    assign w_a_neg   = -w_a;
    assign w_b_neg   = -w_b;
    assign w_c_neg   = -w_c;
    assign w_fsum    = 33'(r_f1) + 33'(w_rd_amp);

    // floor of the signed quotient, plus the segment start amplitude
    assign w_round = r_neg && (r_rem != '0);
    assign w_qq    = {1'b0, r_quo} + 36'(w_round);
    assign w_sv    = r_neg ? -$signed({2'b00, w_qq}) : $signed({2'b00, w_qq});
    assign w_sum   = w_sv + 38'(r_f1);

    always_comb begin
        if (r_qovf) begin
            w_sat = r_neg ? AMP_MIN : AMP_MAX;
        end else if (w_sum > 38'(AMP_MAX)) begin
            w_sat = AMP_MAX;
        end else if (w_sum < 38'(AMP_MIN)) begin
            w_sat = AMP_MIN;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        n_tq         = r_tq;
        n_t1         = r_t1;
        n_f1         = r_f1;
        n_last       = r_last;
        n_k          = r_k;
        n_ts         = r_ts;
        n_dvd        = r_dvd;
        n_dvs        = r_dvs;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_qovf       = r_qovf;
        n_mpl        = r_mpl;
        n_mcd        = r_mcd;
        n_cnt        = r_cnt;
        n_neg        = r_neg;
        n_res_amp    = r_res_amp;
        n_res_status = r_res_status;
        n_from_div   = r_from_div;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_item.operation == OP_EVAL)) begin
                    n_tq    = i_in_item.time_value;
                    n_last  = AW'(w_n - 32'd1);
                    n_state = S_RD_LAST;
                end
            end
            S_RD_LAST: begin
                // first breakpoint arrives
                n_t1    = w_rd_time;
                n_f1    = w_rd_amp;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_res_amp  = '0;
                n_from_div = 1'b0;
                if (r_tq < r_t1) begin
                    n_res_status = ST_BEFORE;
                    n_state      = S_DONE;
                end else if ((r_cutoff > r_t1) && (r_tq > r_cutoff)) begin
                    n_res_status = ST_CUTOFF;
                    n_state      = S_DONE;
                end else if (w_span == '0) begin
                    n_res_status = ST_ZERO_SPAN;
                    n_state      = S_DONE;
                end else begin
                    n_dvd   = {w_offset, 35'd0};
                    n_dvs   = w_span_mag;
                    n_rem   = '0;
                    n_cnt   = 7'd32;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                n_rem = w_rnext;
                n_dvd = {r_dvd[PROD_W-2:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_ts    = 34'(r_t1) + {2'b00, w_rnext[31:0]};
                    n_k     = '0;
                    n_state = S_SEEK_START;
                end
            end
            S_SEEK_START: begin
                n_state = S_SEEK;
            end
            S_SEEK: begin
                if (w_hit || w_at_last) begin
                    n_res_status = ST_INTERP;
                    if (w_c == '0) begin
                        // zero-length segment: floor of the mean
                        n_res_amp  = w_fsum[32:1];
                        n_from_div = 1'b0;
                        n_state    = S_DONE;
                    end else begin
                        n_neg   = w_a[34] ^ w_b[32] ^ w_c[32];
                        n_mpl   = w_a[34] ? w_a_neg[MAG_A_W-1:0] : w_a[MAG_A_W-1:0];
                        n_mcd   = w_b[32] ? 33'(w_b_neg) : 33'(w_b);
                        n_dvs   = w_c[32] ? 33'(w_c_neg) : 33'(w_c);
                        n_dvd   = '0;
                        n_cnt   = 7'(MAG_A_W);
                        n_state = S_MUL;
                    end
                end else begin
                    n_t1 = w_rd_time;
                    n_f1 = w_rd_amp;
                    n_k  = AW'(r_k + AW'(1));
                end
            end
            S_MUL: begin
                n_dvd = {r_dvd[PROD_W-2:0], 1'b0} +
                        (r_mpl[MAG_A_W-1] ? {34'd0, r_mcd} : {PROD_W{1'b0}});
                n_mpl = {r_mpl[MAG_A_W-2:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_rem   = '0;
                    n_quo   = '0;
                    n_qovf  = 1'b0;
                    n_cnt   = 7'(PROD_W);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = w_rnext;
                n_dvd  = {r_dvd[PROD_W-2:0], 1'b0};
                n_quo  = {r_quo[QUO_W-2:0], w_ge};
                n_qovf = r_qovf || r_quo[QUO_W-1];
                n_cnt  = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_from_div = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid      = 1'b1;
                    n_out.amplitude  = r_from_div ? w_sat : r_res_amp;
                    n_out.status     = r_res_status;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_point_count <= 5'd2;
            r_cutoff      <= AMP_MIN;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POINT_COUNT: r_point_count <= i_cfg_data[4:0];
                    CFG_CUTOFF_TIME: r_cutoff      <= $signed(i_cfg_data[31:0]);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_tq         <= n_tq;
        r_t1         <= n_t1;
        r_f1         <= n_f1;
        r_last       <= n_last;
        r_k          <= n_k;
        r_ts         <= n_ts;
        r_dvd        <= n_dvd;
        r_dvs        <= n_dvs;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_qovf       <= n_qovf;
        r_mpl        <= n_mpl;
        r_mcd        <= n_mcd;
        r_cnt        <= n_cnt;
        r_neg        <= n_neg;
        r_res_amp    <= n_res_amp;
        r_res_status <= n_res_status;
        r_from_div   <= n_from_div;
    end

    // a load never starts an evaluation
    `PPWL_ASSERT_NEXT(a_load_stays_idle, w_in_acc && (i_in_item.operation == OP_LOAD), r_state == S_IDLE, "load left idle")
    // the shared divider never runs with a zero divisor
    `PPWL_ASSERT_SAME(a_divisor_nonzero, (r_state == S_MOD) || (r_state == S_DIV), r_dvs != '0, "zero divisor")
    // a result only appears from the finishing state
    `PPWL_ASSERT_SAME(a_result_from_done, $rose(r_out_valid), $past(r_state) == S_DONE, "stray result")

endmodule

// ===== dv/periodic_piecewise_linear_waveform_core_tb.sv =====
// testbench for the piecewise-linear waveform core: loads breakpoint tables, evaluates
// query times under random idling and checks every result against an in-bench predictor
// depends on ppwl_pkg and periodic_piecewise_linear_waveform_core
`timescale 1ns / 1ps

// predicts evaluate results and holds them until the core delivers them
class waveform_scoreboard;
    logic signed [31:0] bp_time[16];
    logic signed [31:0] bp_amp[16];
    logic [4:0] count_reg;
    logic signed [31:0] cutoff_reg;
    ppwl_pkg::t_out_item expected_q[$];
    int mismatches;
    int checked;

    function new();
        count_reg = 5'd2;
        cutoff_reg = ppwl_pkg::AMP_MIN;
        mismatches = 0;
        checked = 0;
        foreach (bp_time[i]) begin
            bp_time[i] = '0;
            bp_amp[i] = '0;
        end
    endfunction

    function void set_config(logic [4:0] count, logic signed [31:0] cutoff);
        count_reg = count;
        cutoff_reg = cutoff;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // floor(a * b / c) on wide signed arithmetic
    function logic signed [127:0] floor_muldiv(longint a, longint b, longint c);
        logic signed [127:0] p;
        logic signed [127:0] d;
        logic signed [127:0] q;
        p = a;
        p = p * b;
        d = c;
        q = p / d;
        if ((p % d) != 0 && ((p < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function ppwl_pkg::t_out_item interpolate(longint tq);
        ppwl_pkg::t_out_item res;
        int n;
        longint t0, span, mag, ts, t1, t2, f1, f2;
        logic signed [127:0] wide;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > 16) n = 16;
        t0 = bp_time[0];
        span = longint'(bp_time[n-1]) - t0;
        res.amplitude = '0;
        res.status = ppwl_pkg::ST_INTERP;
        if (tq < t0) begin
            res.status = ppwl_pkg::ST_BEFORE;
        end else if (longint'(cutoff_reg) > t0 && tq > cutoff_reg) begin
            res.status = ppwl_pkg::ST_CUTOFF;
        end else if (span == 0) begin
            res.status = ppwl_pkg::ST_ZERO_SPAN;
        end else begin
            mag = (span < 0) ? -span : span;
            ts = t0 + (tq - t0) % mag;
            t1 = 0; t2 = 0; f1 = 0; f2 = 0;
            // first containing segment, else the last one is extrapolated
            for (int k = 0; k < n - 1; k++) begin
                t1 = bp_time[k];
                t2 = bp_time[k+1];
                f1 = bp_amp[k];
                f2 = bp_amp[k+1];
                if (ts <= t2 && ts >= t1) break;
            end
            if (t1 == t2)
                wide = (f1 + f2) >>> 1;
            else
                wide = f1 + floor_muldiv(ts - t1, f2 - f1, t2 - t1);
            if (wide > 128'sd2147483647) wide = 128'sd2147483647;
            if (wide < -128'sd2147483648) wide = -128'sd2147483648;
            res.amplitude = wide[31:0];
        end
        return res;
    endfunction

    function void note_input(ppwl_pkg::t_in_item it);
        if (it.operation == ppwl_pkg::OP_LOAD) begin
            bp_time[it.point_index] = it.time_value;
            bp_amp[it.point_index] = it.amp_value;
        end else begin
            expected_q.push_back(interpolate(it.time_value));
        end
    endfunction

    task report(string what);
        mismatches++;
        $display("[%0t] error: %s", $time, what);
    endtask

    task check_result(ppwl_pkg::t_out_item got);
        ppwl_pkg::t_out_item want;
        checked++;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected result amp=%h status=%0d", got.amplitude, got.status));
        end else begin
            want = expected_q.pop_front();
            if (got.amplitude !== want.amplitude)
                report($sformatf("amplitude %h, predicted %h", got.amplitude, want.amplitude));
            if (got.status !== want.status)
                report($sformatf("status %0d, predicted %0d", got.status, want.status));
        end
    endtask
endclass

module periodic_piecewise_linear_waveform_core_tb;
    import ppwl_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    t_out_item o_out_item;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    waveform_scoreboard sb;
    int items_sent;
    int phases_run;
    int hold_tokens;     // bumped by the stimulus to ask for a long output hold
    logic calm;          // no input gaps in this stretch

    periodic_piecewise_linear_waveform_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: far above the slowest legal run
    initial begin
        #40000000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("Mismatches found");
        $finish;
    end

    // mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // offer one item and hold it until accepted, then idle for a random gap
    task send_item(t_in_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task send_load(logic [3:0] idx, logic signed [31:0] t, logic signed [31:0] a);
        t_in_item it;
        it.operation = OP_LOAD;
        it.point_index = idx;
        it.time_value = t;
        it.amp_value = a;
        send_item(it);
    endtask

    // unused fields carry random bits so they get exercised too
    task send_eval(logic signed [31:0] t);
        t_in_item it;
        it.operation = OP_EVAL;
        it.point_index = $urandom();
        it.time_value = t;
        it.amp_value = $urandom();
        send_item(it);
    endtask

    // stop offering and wait out every pending result plus the worst evaluate latency
    task drain();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // both registers written back to back, only while the core is idle
    task program_config(logic [4:0] count, logic signed [31:0] cutoff);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_POINT_COUNT;
        i_cfg_data <= {27'd0, count};
        @(posedge i_clk);
        i_cfg_idx <= CFG_CUTOFF_TIME;
        i_cfg_data <= cutoff;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_config(count, cutoff);
        phases_run++;
    endtask

    // output side: check accepted results, stall in random runs
    initial begin
        int run_left;
        int hold_seen;
        int hold_left;
        run_left = 0;
        hold_seen = 0;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_result(o_out_item);
            if (hold_tokens != hold_seen) begin
                hold_seen = hold_tokens;
                hold_left = 700;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_left = ($urandom_range(99) < 6) ? $urandom_range(60, 20)
                                                        : $urandom_range(6, 1);
                    // each new run is picked at random: a stall run, or a free run four times as long
                    if ($urandom_range(2) == 0)
                        i_out_stall <= 1'b1;
                    else begin
                        i_out_stall <= 1'b0;
                        run_left = run_left * 4;
                    end
                end
                run_left--;
            end
        end
    end

    // one table setting: sorted, with flat steps, scrambled or with zero span
    task run_phase(int kind);
        logic [4:0] count_list[10] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd8,
                                       5'd15, 5'd16, 5'd17, 5'd31};
        logic [4:0] count;
        int n, evals, sel;
        longint ptime[16];
        longint t0, step_max, span, mag, off, tq;
        logic signed [31:0] cutoff, amp;
        count = count_list[$urandom_range(9)];
        n = (count < 2) ? 2 : (count > 16) ? 16 : count;
        case ($urandom_range(2))
            0: step_max = 16;
            1: step_max = 65536;
            default: step_max = 64'd1 << 26;
        endcase
        t0 = longint'($signed($urandom())) >>> 1;
        if (t0 > 0) t0 = -t0;
        for (int i = 0; i < n; i++) begin
            if (kind == 2)
                ptime[i] = longint'($signed($urandom()));
            else if (i == 0)
                ptime[i] = t0;
            else if (kind == 1 && $urandom_range(2) == 0)
                ptime[i] = ptime[i-1];
            else
                ptime[i] = ptime[i-1] + $urandom_range(step_max, 1);
        end
        if (kind == 3) ptime[n-1] = ptime[0];
        t0 = ptime[0];
        span = ptime[n-1] - t0;
        mag = (span < 0) ? -span : span;
        case ($urandom_range(4))
            0: cutoff = AMP_MIN;
            1: cutoff = AMP_MAX;
            2: cutoff = clamp32(t0);
            3: cutoff = clamp32(t0 + mag + (mag >> 1) + 1);
            default: cutoff = $urandom();
        endcase
        drain();
        program_config(count, cutoff);
        calm = ($urandom_range(3) == 0);
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(9);
            amp = (sel == 0) ? AMP_MAX : (sel == 1) ? AMP_MIN :
                  (sel < 5) ? $signed($urandom_range(1 << 20)) - 32'sd524288 : $urandom();
            send_load(i[3:0], ptime[i][31:0], amp);
        end
        evals = $urandom_range(40, 10);
        for (int j = 0; j < evals; j++) begin
            sel = $urandom_range(99);
            if (sel < 70 && mag < (64'd1 << 31)) begin
                off = ((longint'($urandom()) >> 8) * (5 * mag + 8)) >>> 24;
                tq = t0 - (mag >> 3) - 2 + off;
            end else if (sel < 85) begin
                tq = ptime[$urandom_range(n - 1)] + $signed($urandom_range(2)) - 1;
            end else begin
                tq = longint'($signed($urandom()));
            end
            send_eval(clamp32(tq));
        end
    endtask

    initial begin
        int kind;
        sb = new();
        items_sent = 0;
        phases_run = 0;
        hold_tokens = 0;
        calm = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_POINT_COUNT;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: two points across the whole non-negative time range at reset settings
        send_load(4'd0, 32'sd0, AMP_MIN);
        send_load(4'd1, AMP_MAX, AMP_MAX);
        send_eval(-32'sd1);             // before the first breakpoint
        send_eval(32'sd0);
        send_eval(AMP_MAX);             // wraps back onto the start
        send_eval(32'sh3FFF_FFFF);      // middle of the full swing
        send_eval(AMP_MIN);
        // remaining entries so any point count only reads written entries
        for (int i = 2; i < 16; i++)
            send_load(i[3:0], 32'sh7FFF_0000 + i, (i % 2) ? AMP_MIN : AMP_MAX);
        send_load(4'd1, 32'sd0, 32'sd5);
        send_eval(32'sd100);            // zero span
        send_load(4'd1, 32'sd0, -32'sd5);
        send_eval(32'sd0);              // zero span again, now with a negative amplitude
        drain();
        program_config(5'd2, 32'sd10);
        send_load(4'd1, 32'sd1000, 32'sd7);
        send_eval(32'sd11);             // after the cutoff
        send_eval(32'sd10);

        // random phases; the third one holds the output while items keep coming
        while (items_sent < 1400) begin
            kind = $urandom_range(99);
            kind = (kind < 60) ? 0 : (kind < 75) ? 1 : (kind < 90) ? 2 : 3;
            if (phases_run == 3) begin
                drain();
                program_config(5'd16, AMP_MIN);
                hold_tokens++;
                calm = 1'b1;
                for (int j = 0; j < 30; j++) send_eval($urandom());
            end else begin
                run_phase(kind);
            end
        end

        drain();
        $display("%0d items offered over %0d table settings, %0d results checked",
                 items_sent, phases_run, sb.checked);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ppwl_pkg.sv
rtl/ppwl_ram.sv
rtl/periodic_piecewise_linear_waveform_core.sv
dv/periodic_piecewise_linear_waveform_core_tb.sv
